// ----- hdl/i2c_bit_level_master_top_macros.svh -----
// assertion macros shared by the checker
`ifndef I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH

// checked outside reset
`define I2CM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define I2CM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/i2cm_pkg.sv -----
package i2cm_pkg;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START_A  = 4'd1,
      PH_START_B  = 4'd2,
      PH_STOP_A   = 4'd3,
      PH_STOP_B   = 4'd4,
      PH_WR_LOW   = 4'd5,
      PH_WR_HIGH  = 4'd6,
      PH_ACK_REL  = 4'd7,
      PH_ACK_POLL = 4'd8,
      PH_RD_REL   = 4'd9,
      PH_RD_HIGH  = 4'd10,
      PH_RD_LOW   = 4'd11,
      PH_ANS_LOW  = 4'd12,
      PH_ANS_HIGH = 4'd13
   } phase_type;

   localparam logic [3:0] ACK_WAIT_LIMIT_RESET = 4'd5;
   localparam logic [3:0] BITS_PER_BYTE       = 4'd8;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] wdata;
      logic       send_ack;
      logic       sda_sample;
   } req_item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic [3:0] ack_wait;
   } rsp_item_type;

endpackage

// ----- hdl/i2cm_if.sv -----
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] wdata;
   logic       send_ack;
   logic       sda_sample;

   modport source (output valid, output op, output wdata, output send_ack,
                   output sda_sample, input ready);
   modport sink (input valid, input op, input wdata, input send_ack,
                 input sda_sample, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_byte;
   logic [3:0] ack_wait;

   modport source (output valid, output scl_level, output sda_level, output busy_res,
                   output done_res, output read_byte, output ack_wait, input ready);
   modport sink (input valid, input scl_level, input sda_level, input busy_res,
                 input done_res, input read_byte, input ack_wait, output ready);
endinterface

// ----- hdl/i2cm_tick.sv -----
module i2cm_tick
   import i2cm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  logic [3:0]   ack_wait_limit,
   output rsp_item_type result
);

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_index_ff, bit_index_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] wait_count_ff, wait_count_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       ack_choice_ff, ack_choice_in;
   logic [7:0] last_read_ff, last_read_in;

   phase_type  ph;
   logic       busy;
   logic       done;
   logic       scl_low_after;
   logic       scl_now;
   logic       sda_now;

   always_comb begin
      ph            = phase_ff;
      shift_in      = shift_ff;
      bit_index_in  = bit_index_ff;
      wait_count_in = wait_count_ff;
      ack_choice_in = ack_choice_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      last_read_in  = last_read_ff;
      busy          = 1'b0;
      done          = 1'b0;
      scl_low_after = 1'b0;

      // command is taken only when idle
      if (phase_ff == PH_IDLE) begin
         case (item.op)
            OP_START: begin
               ph = PH_START_A;
            end
            OP_STOP: begin
               ph = PH_STOP_A;
            end
            OP_WRITE: begin
               ph            = PH_WR_LOW;
               shift_in      = item.wdata;
               bit_index_in  = '0;
               wait_count_in = '0;
            end
            OP_READ: begin
               ph            = PH_RD_REL;
               shift_in      = '0;
               bit_index_in  = '0;
               ack_choice_in = item.send_ack;
            end
            default: ;
         endcase
      end

      phase_in = ph;
      busy     = (ph != PH_IDLE);

      case (ph)
         PH_START_A: begin
            sda_in = 1'b1; scl_in = 1'b1; phase_in = PH_START_B;
         end
         PH_START_B: begin
            sda_in = 1'b0; scl_in = 1'b1;
            done = 1'b1; scl_low_after = 1'b1; phase_in = PH_IDLE;
         end
         PH_STOP_A: begin
            sda_in = 1'b0; scl_in = 1'b1; phase_in = PH_STOP_B;
         end
         PH_STOP_B: begin
            sda_in = 1'b1; scl_in = 1'b1;
            done = 1'b1; phase_in = PH_IDLE;
         end
         PH_WR_LOW: begin
            sda_in = shift_in[7]; scl_in = 1'b0; phase_in = PH_WR_HIGH;
         end
         PH_WR_HIGH: begin
            scl_in        = 1'b1;
            scl_low_after = 1'b1;
            bit_index_in  = bit_index_in + 4'd1;
            phase_in      = (bit_index_in >= BITS_PER_BYTE) ? PH_ACK_REL : PH_WR_LOW;
         end
         PH_ACK_REL: begin
            sda_in = 1'b1; scl_in = 1'b0; phase_in = PH_ACK_POLL;
         end
         PH_ACK_POLL: begin
            sda_in = 1'b1; scl_in = 1'b1;
            if (item.sda_sample && (wait_count_in < ack_wait_limit)) begin
               wait_count_in = wait_count_in + 4'd1;
            end else begin
               done = 1'b1; scl_low_after = 1'b1; phase_in = PH_IDLE;
            end
         end
         PH_RD_REL: begin
            sda_in = 1'b1; scl_in = 1'b0; phase_in = PH_RD_HIGH;
         end
         PH_RD_HIGH: begin
            scl_in = 1'b1; phase_in = PH_RD_LOW;
         end
         PH_RD_LOW: begin
            scl_in       = 1'b0;
            bit_index_in = bit_index_in + 4'd1;
            phase_in     = (bit_index_in >= BITS_PER_BYTE) ? PH_ANS_LOW : PH_RD_HIGH;
         end
         PH_ANS_LOW: begin
            sda_in = ~ack_choice_in; scl_in = 1'b0; phase_in = PH_ANS_HIGH;
         end
         PH_ANS_HIGH: begin
            scl_in = 1'b1;
            done = 1'b1; scl_low_after = 1'b1; phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      scl_now = scl_in;
      sda_now = sda_in;

      // updates after this tick's levels are shown
      if (ph == PH_WR_HIGH) begin
         shift_in = {shift_in[6:0], 1'b0};
      end
      if (ph == PH_RD_HIGH) begin
         shift_in = {shift_in[6:0], item.sda_sample};
      end
      if (ph == PH_ANS_HIGH) begin
         last_read_in = shift_in;
      end
      if (scl_low_after) begin
         scl_in = 1'b0;
      end
   end

   always_comb begin
      result.scl_level = scl_now;
      result.sda_level = sda_now;
      result.busy_res  = busy;
      result.done_res  = done;
      result.read_byte = last_read_in;
      result.ack_wait  = wait_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         wait_count_ff <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_choice_ff <= 1'b0;
         last_read_ff  <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         wait_count_ff <= wait_count_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         ack_choice_ff <= ack_choice_in;
         last_read_ff  <= last_read_in;
      end
   end

endmodule

// ----- hdl/i2c_bit_level_master_top.sv -----
// path: an accepted transaction waits in the input register; its result is registered
// throughput: one tick per cycle while the result register is free or being read, set
//   by the single-pass step between the input register and the result register
// reset: synchronous, active high; empties both registers, releases scl and sda,
//   clears the bus state and sets ack_wait_limit to 5
module i2c_bit_level_master_top
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req_chan,
   i2cm_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic [3:0]   limit_ff;

   logic         advance;
   logic         req_take;
   rsp_item_type tick_result;

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in         = 1'b1;
         in_item_in.op         = req_chan.op;
         in_item_in.wdata      = req_chan.wdata;
         in_item_in.send_ack   = req_chan.send_ack;
         in_item_in.sda_sample = req_chan.sda_sample;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = tick_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   i2cm_tick u_tick (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .item           (in_item_ff),
      .ack_wait_limit (limit_ff),
      .result         (tick_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= ACK_WAIT_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_level = rsp_item_ff.scl_level;
   assign rsp_chan.sda_level = rsp_item_ff.sda_level;
   assign rsp_chan.busy_res  = rsp_item_ff.busy_res;
   assign rsp_chan.done_res  = rsp_item_ff.done_res;
   assign rsp_chan.read_byte = rsp_item_ff.read_byte;
   assign rsp_chan.ack_wait  = rsp_item_ff.ack_wait;

endmodule

// ----- hdl/i2cm_checker.sv -----
`include "i2c_bit_level_master_top_macros.svh"

module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl_level,
   input logic       rsp_sda_level,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_byte,
   input logic [3:0] rsp_ack_wait
);

   logic        rsp_stall;
   logic [15:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_scl_level, rsp_sda_level, rsp_busy_res, rsp_done_res,
                         rsp_read_byte, rsp_ack_wait};

   // a finishing tick always belongs to a command
   `I2CM_ASSERT(a_done_in_busy, rsp_valid && rsp_done_res |-> rsp_busy_res, "done without busy")

   // a stalled transaction holds its payload
   `I2CM_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled result changed")

   // no result right after reset
   `I2CM_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind i2c_bit_level_master_top i2cm_checker u_i2cm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_scl_level (rsp_chan.scl_level),
   .rsp_sda_level (rsp_chan.sda_level),
   .rsp_busy_res  (rsp_chan.busy_res),
   .rsp_done_res  (rsp_chan.done_res),
   .rsp_read_byte (rsp_chan.read_byte),
   .rsp_ack_wait  (rsp_chan.ack_wait)
);
